### hdl/auto_load_keystroke_typist_assert.svh
// Assertion macros shared by the auto-load typist modules.
`ifndef AUTO_LOAD_KEYSTROKE_TYPIST_ASSERT_SVH
`define AUTO_LOAD_KEYSTROKE_TYPIST_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ALKT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alkt assertion failed");

// Check that cons holds in the cycle after ante.
`define ALKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alkt assertion failed");

`endif

### hdl/alkt_pkg.sv
// Package: command, step and mode codes plus the key step table.
package alkt_pkg;

    localparam logic [1:0] CMD_READ     = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_ACTIVATE = 2'd2;

    localparam logic [1:0] MODE_J     = 2'd0;
    localparam logic [1:0] MODE_ENTER = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    localparam logic [3:0] STEP_IDLE       = 4'd0;
    localparam logic [3:0] STEP_WAIT       = 4'd1;
    localparam logic [3:0] STEP_J          = 4'd2;
    localparam logic [3:0] STEP_QUOTE1     = 4'd3;
    localparam logic [3:0] STEP_QUOTE2     = 4'd4;
    localparam logic [3:0] STEP_ENTER      = 4'd5;
    localparam logic [3:0] STEP_ENTER_ONLY = 4'd6;
    localparam logic [3:0] STEP_L          = 4'd7;
    localparam logic [3:0] STEP_O          = 4'd8;
    localparam logic [3:0] STEP_A          = 4'd9;
    localparam logic [3:0] STEP_D          = 4'd10;

    localparam logic [7:0] NO_KEYS = 8'hff;

    typedef struct packed {
        logic       has_a;
        logic [2:0] row_a;
        logic [2:0] col_a;
        logic       has_b;
        logic [2:0] row_b;
        logic [2:0] col_b;
        logic [3:0] next;
        logic [3:0] delay;
    } step_info_t;

    function automatic step_info_t step_info(input logic [3:0] step);
        step_info_t s;
        s = '0;
        case (step)
            STEP_J:          s = '{1'b1, 3'd6, 3'd3, 1'b0, 3'd0, 3'd0, STEP_QUOTE1, 4'd8};
            STEP_QUOTE1:     s = '{1'b1, 3'd7, 3'd1, 1'b1, 3'd5, 3'd0, STEP_QUOTE2, 4'd0};
            STEP_QUOTE2:     s = '{1'b1, 3'd7, 3'd1, 1'b1, 3'd5, 3'd0, STEP_ENTER, 4'd5};
            STEP_ENTER:      s = '{1'b1, 3'd6, 3'd0, 1'b0, 3'd0, 3'd0, STEP_IDLE, 4'd0};
            STEP_ENTER_ONLY: s = '{1'b1, 3'd6, 3'd0, 1'b0, 3'd0, 3'd0, STEP_IDLE, 4'd3};
            STEP_L:          s = '{1'b1, 3'd6, 3'd1, 1'b0, 3'd0, 3'd0, STEP_O, 4'd2};
            STEP_O:          s = '{1'b1, 3'd5, 3'd1, 1'b0, 3'd0, 3'd0, STEP_A, 4'd0};
            STEP_A:          s = '{1'b1, 3'd1, 3'd0, 1'b0, 3'd0, 3'd0, STEP_D, 4'd4};
            STEP_D:          s = '{1'b1, 3'd1, 3'd2, 1'b0, 3'd0, 3'd0, STEP_QUOTE1, 4'd4};
            default:         s = '0;
        endcase
        return s;
    endfunction

    // Active-low column bits for one key if its row is selected.
    function automatic logic [7:0] press(input logic [7:0] row_sel, input logic has_key,
                                         input logic [2:0] row, input logic [2:0] col);
        logic [7:0] r;
        r = NO_KEYS;
        if (has_key && !row_sel[row])
            r = ~(8'd1 << col);
        return r;
    endfunction

    function automatic logic [3:0] first_step(input logic [1:0] mode);
        logic [3:0] s;
        case (mode)
            MODE_J:     s = STEP_J;
            MODE_ENTER: s = STEP_ENTER_ONLY;
            MODE_LOAD:  s = STEP_L;
            default:    s = STEP_IDLE;
        endcase
        return s;
    endfunction

endpackage

### hdl/alkt_core.sv
// Step sequencer: holds the typist state and forms the key bits of a read.
`include "auto_load_keystroke_typist_assert.svh"

module alkt_core
    import alkt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       strobe,
    input  logic [1:0] command,
    input  logic [7:0] row_sel,
    input  logic [1:0] mode,
    output logic [7:0] rdata
);

    logic [3:0] cur_step_reg,  cur_step_next;
    logic [3:0] pend_step_reg, pend_step_next;
    logic [3:0] wait_reg,      wait_next;
    logic [7:0] rows_reg,      rows_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_step_reg  <= STEP_IDLE;
            pend_step_reg <= STEP_IDLE;
            wait_reg      <= '0;
            rows_reg      <= '0;
        end
        else
        begin
            cur_step_reg  <= cur_step_next;
            pend_step_reg <= pend_step_next;
            wait_reg      <= wait_next;
            rows_reg      <= rows_next;
        end
    end

    always_comb
    begin
        step_info_t cur_info;
        step_info_t pend_info;
        logic [7:0] row_hit;
        logic       single_row;
        logic [3:0] wait_load;

        cur_info       = step_info(cur_step_reg);
        pend_info      = step_info(pend_step_reg);
        row_hit        = ~row_sel;
        single_row     = (row_hit != 8'd0) && ((row_hit & (row_hit - 8'd1)) == 8'd0);
        wait_load      = wait_reg;
        cur_step_next  = cur_step_reg;
        pend_step_next = pend_step_reg;
        wait_next      = wait_reg;
        rows_next      = rows_reg;
        rdata          = NO_KEYS;

        if (strobe)
        begin
            case (command)
                CMD_READ:
                begin
                    if (wait_reg == 4'd0)
                    begin
                        if (cur_step_reg == STEP_WAIT)
                        begin
                            rows_next = rows_reg | (single_row ? row_hit : 8'd0);
                            if (rows_next == 8'hff)
                                pend_step_next = first_step(mode);
                        end
                        else if (cur_step_reg inside {[STEP_J:STEP_D]})
                        begin
                            rdata = press(row_sel, cur_info.has_a, cur_info.row_a,
                                          cur_info.col_a)
                                  & press(row_sel, cur_info.has_b, cur_info.row_b,
                                          cur_info.col_b);
                            pend_step_next = cur_info.next;
                        end
                    end
                end
                CMD_TICK:
                begin
                    rows_next = '0;
                    if (pend_step_reg != cur_step_reg)
                    begin
                        cur_step_next = pend_step_reg;
                        wait_load     = pend_info.delay;
                    end
                    wait_next = (wait_load != 4'd0) ? wait_load - 4'd1 : wait_load;
                end
                CMD_ACTIVATE:
                begin
                    cur_step_next  = STEP_WAIT;
                    pend_step_next = STEP_WAIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    `ALKT_ASSERT_NOW(a_step_reachable, 1'b1, cur_step_reg <= STEP_D)
    `ALKT_ASSERT_NOW(a_delay_blanks, strobe && command == CMD_READ && wait_reg != 4'd0,
                     rdata == NO_KEYS)
    `ALKT_ASSERT_NEXT(a_tick_clears_rows, strobe && command == CMD_TICK, rows_reg == 8'd0)

endmodule

### hdl/auto_load_keystroke_typist.sv
// Auto-load typist: injects a key sequence into keyboard port reads.
// A read word passes through the input register and then the result register.
// Throughput: one word per cycle; only a stalled result register slows intake.
// Frame ticks and activates update state and produce no result word.
// Reset (rst_n, async, active low) clears all step state, the mode and valids.
`include "auto_load_keystroke_typist_assert.svh"

module auto_load_keystroke_typist
    import alkt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] port_address,
    // result words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    // mode register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  operating_mode
);

    // Input register: hold one word until the result side can take it.
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_cmd_reg;
    logic [7:0] s1_rows_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic [1:0] mode_reg;

    logic       in_take;
    logic       s1_go;
    logic [7:0] core_rdata;

    // Advance the input register whenever the result register is free or draining.
    assign s1_go    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_go && s1_cmd_reg == CMD_READ)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_J;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= operating_mode;
        end
    end

    // Payload: capture on acceptance, drop the low address byte.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= command;
            s1_rows_reg <= port_address[15:8];
        end
        if (s1_go && s1_cmd_reg == CMD_READ)
            out_data_reg <= core_rdata;
    end

    // Sequencer commits its state on the same edge the word leaves the input register.
    alkt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .strobe  (s1_go),
        .command (s1_cmd_reg),
        .row_sel (s1_rows_reg),
        .mode    (mode_reg),
        .rdata   (core_rdata)
    );

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

    `ALKT_ASSERT_NOW(a_stall_when_blocked, s1_valid_reg && out_valid_reg && out_stall, in_stall)
    `ALKT_ASSERT_NOW(a_upper_bits_idle, out_valid_reg, read_data[7:5] == 3'b111)
    `ALKT_ASSERT_NEXT(a_read_gives_word, s1_go && s1_cmd_reg == CMD_READ, out_valid_reg)

endmodule
